[hdl/b64sc_pkg.sv]
// Shared types, constants and alphabet functions for the base64 stream codec.
`default_nettype none
package b64sc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_DIRECTION = 1'b0;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Up to four result characters or bytes produced by one input item
  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] chars;
  } b64sc_job_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Characters outside the alphabet map to zero
  function automatic logic [5:0] six_bits(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else begin
      v = 8'd0;
    end
    return v[5:0];
  endfunction

endpackage
`default_nettype wire

[hdl/b64sc_front.sv]
// Front end: accepts items, tracks group state and builds result jobs.
`default_nettype none
module b64sc_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 direction,
  input  wire logic                 cfg_clear,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_data,
  input  wire logic                 in_last,
  input  wire logic                 q_full,
  output logic                      q_push,
  output b64sc_pkg::b64sc_job_t     q_job
);
  import b64sc_pkg::*;

  logic [1:0] phase, phase_next;
  logic [5:0] left, left_next;
  logic       pad_seen, pad_seen_next;
  logic [5:0] v;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign v        = six_bits(in_data);

  always_comb begin
    phase_next    = phase;
    left_next     = left;
    pad_seen_next = pad_seen;
    q_job.count   = 3'd0;
    q_job.chars   = '0;
    if (direction == DIR_ENCODE) begin
      case (phase)
        2'd0: begin
          q_job.chars[0] = sym(in_data[7:2]);
          left_next      = {in_data[1:0], 4'b0000};
          phase_next     = 2'd1;
          q_job.count    = 3'd1;
        end
        2'd1: begin
          q_job.chars[0] = sym(left | {2'b00, in_data[7:4]});
          left_next      = {in_data[3:0], 2'b00};
          phase_next     = 2'd2;
          q_job.count    = 3'd1;
        end
        default: begin
          q_job.chars[0] = sym(left | {4'b0000, in_data[7:6]});
          q_job.chars[1] = sym(in_data[5:0]);
          left_next      = 6'd0;
          phase_next     = 2'd0;
          q_job.count    = 3'd2;
        end
      endcase
      if (in_last) begin
        // flush the partial character and pad out the group
        if (phase_next == 2'd1) begin
          q_job.chars[1] = sym(left_next);
          q_job.chars[2] = PAD_CHAR;
          q_job.chars[3] = PAD_CHAR;
          q_job.count    = 3'd4;
        end else if (phase_next == 2'd2) begin
          q_job.chars[1] = sym(left_next);
          q_job.chars[2] = PAD_CHAR;
          q_job.count    = 3'd3;
        end
        phase_next    = 2'd0;
        left_next     = 6'd0;
        pad_seen_next = 1'b0;
      end
    end else begin
      if (!pad_seen) begin
        if (in_data == PAD_CHAR) begin
          pad_seen_next = 1'b1;
        end else begin
          case (phase)
            2'd0: begin
              left_next  = v;
              phase_next = 2'd1;
            end
            2'd1: begin
              q_job.chars[0] = {left[5:0], v[5:4]};
              q_job.count    = 3'd1;
              left_next      = {2'b00, v[3:0]};
              phase_next     = 2'd2;
            end
            2'd2: begin
              q_job.chars[0] = {left[3:0], v[5:2]};
              q_job.count    = 3'd1;
              left_next      = {4'b0000, v[1:0]};
              phase_next     = 2'd3;
            end
            default: begin
              q_job.chars[0] = {left[1:0], v};
              q_job.count    = 3'd1;
              left_next      = 6'd0;
              phase_next     = 2'd0;
            end
          endcase
        end
      end
      if (in_last) begin
        phase_next    = 2'd0;
        left_next     = 6'd0;
        pad_seen_next = 1'b0;
      end
    end
  end

  assign q_push = accept && (q_job.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      phase    <= 2'd0;
      left     <= 6'd0;
      pad_seen <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      left     <= left_next;
      pad_seen <= pad_seen_next;
    end
  end

endmodule
`default_nettype wire

[hdl/b64sc_queue.sv]
// Short job queue between the front end and the output stage.
`default_nettype none
module b64sc_queue #(
  parameter int unsigned DEPTH = b64sc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire b64sc_pkg::b64sc_job_t push_job,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output b64sc_pkg::b64sc_job_t     head_job
);
  import b64sc_pkg::*;

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  b64sc_job_t         entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push, do_pop;

  assign full      = (fill == FULL_FILL);
  assign not_empty = (fill != '0);
  assign head_job  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/b64sc_back.sv]
// Output stage: holds one job and sends its results one item per cycle while out_ready is high.
`default_nettype none
module b64sc_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_not_empty,
  input  wire b64sc_pkg::b64sc_job_t q_job,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_data,
  output logic                       out_last
);
  import b64sc_pkg::*;

  b64sc_job_t job;
  logic       job_valid;
  logic [1:0] idx;
  logic       at_last;
  logic       sent;

  assign at_last   = ({1'b0, idx} == (job.count - 3'd1));
  assign sent      = job_valid && out_ready;
  // take the next job when none is held or as the last item of the current one leaves
  assign q_pop     = q_not_empty && (!job_valid || (sent && at_last));
  assign out_valid = job_valid;
  assign out_data  = job.chars[idx];
  assign out_last  = at_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      job_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (sent && at_last) begin
      job_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (sent) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

[hdl/base64_stream_codec_top.sv]
// Top level of the base64 stream codec: register port, front end, queue, output stage.
//
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------
//  s_*       | in        | tdata: data_in [7:0]; tlast: end_of_message
//  m_*       | out       | tdata: data_out [7:0]; tlast: last_of_run
//  APB       | in/out    | direction at byte address 0
//
// An input item is classified in the cycle it is accepted; its results enter the queue
// as one job. The output stage sends one result item per cycle, so an encoded byte
// yields one or two items mid-stream and up to four at message end; the output port
// sets the rate. Input stalls only when the queue is full. Reset clears all control
// state and sets direction to encode; a direction write also clears the group state.
`default_nettype none
module base64_stream_codec_top #(
  parameter int unsigned QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // [7:0] data_in
  input  wire logic                        s_tlast,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,  // [7:0] data_out
  output logic                             m_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [b64sc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import b64sc_pkg::*;

  logic       direction;
  logic       cfg_clear;
  logic       q_full, q_push, q_pop, q_not_empty;
  b64sc_job_t push_job, head_job;

  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
  assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_clear) begin
      direction <= pwdata[0];
    end
  end

  b64sc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .cfg_clear (cfg_clear),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  b64sc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata),
    .out_last    (m_tlast)
  );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for base64_stream_codec_top: random and directed streams checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import b64sc_pkg::*;

  localparam int REG_SPARE = 1;        // unmapped register index, writes must be ignored
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int SEGMENT_ITEMS = 42;
  localparam logic [0:63][7:0] B64_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'h00;   // [7:0] data_in
  logic               s_tlast = 1'b0;    // end_of_message
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;           // [7:0] data_out
  logic               m_tlast;           // last_of_run
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = 32'h0;
  logic [31:0]        prdata;
  logic               pready;

  base64_stream_codec_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  byte_stream[$];
  out_item_t codec_expected[$];
  int        items_queued = 0;
  int        items_taken = 0;
  int        mismatches = 0;
  int        tx_idle_pct = 18;
  int        rx_idle_pct = 71;
  int        quiet_cycles = 0;

  // Predictor state
  logic       dir_mode = DIR_ENCODE;
  logic [1:0] grp_pos = 2'd0;
  logic [5:0] carry_bits = 6'd0;
  logic       pad_hit = 1'b0;

  function automatic logic [5:0] value_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - "A");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd52);
    if (c == "+") return 6'd62;
    if (c == "/") return 6'd63;
    return 6'd0;
  endfunction

  task automatic clear_group();
    grp_pos = 2'd0;
    carry_bits = 6'd0;
    pad_hit = 1'b0;
  endtask

  task automatic predict_codec(input logic [7:0] b, input logic eom);
    logic [7:0] res[$];
    logic [5:0] v;
    if (dir_mode == DIR_ENCODE) begin
      case (grp_pos)
        2'd0: begin
          res.push_back(B64_CHARS[b[7:2]]);
          carry_bits = {b[1:0], 4'b0000};
          grp_pos = 2'd1;
        end
        2'd1: begin
          res.push_back(B64_CHARS[carry_bits | {2'b00, b[7:4]}]);
          carry_bits = {b[3:0], 2'b00};
          grp_pos = 2'd2;
        end
        default: begin
          res.push_back(B64_CHARS[carry_bits | {4'b0000, b[7:6]}]);
          res.push_back(B64_CHARS[b[5:0]]);
          carry_bits = 6'd0;
          grp_pos = 2'd0;
        end
      endcase
      if (eom) begin
        // flush the partial character, then pad the group out to four
        if (grp_pos != 2'd0) res.push_back(B64_CHARS[carry_bits]);
        if (grp_pos == 2'd1) res.push_back(PAD_CHAR);
        if (grp_pos != 2'd0) res.push_back(PAD_CHAR);
        clear_group();
      end
    end else begin
      if (!pad_hit) begin
        if (b == PAD_CHAR) begin
          pad_hit = 1'b1;
        end else begin
          v = value_of(b);
          case (grp_pos)
            2'd0: begin
              carry_bits = v;
              grp_pos = 2'd1;
            end
            2'd1: begin
              res.push_back({carry_bits, v[5:4]});
              carry_bits = {2'b00, v[3:0]};
              grp_pos = 2'd2;
            end
            2'd2: begin
              res.push_back({carry_bits[3:0], v[5:2]});
              carry_bits = {4'b0000, v[1:0]};
              grp_pos = 2'd3;
            end
            default: begin
              res.push_back({carry_bits[1:0], v});
              carry_bits = 6'd0;
              grp_pos = 2'd0;
            end
          endcase
        end
      end
      if (eom) clear_group();
    end
    foreach (res[k]) codec_expected.push_back('{data: res[k], last: (k == res.size() - 1)});
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t ns: %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Source side: hold an item until taken, then load the next unless idling
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_codec(s_tdata, s_tlast);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_tdata  <= byte_stream[0].data;
          s_tlast  <= byte_stream[0].eom;
          s_tvalid <= 1'b1;
          void'(byte_stream.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: compare every accepted item with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (codec_expected.size() == 0) begin
          flag_mismatch("unexpected output item", 32'h0, {23'h0, m_tlast, m_tdata});
        end else begin
          want = codec_expected.pop_front();
          if (m_tdata !== want.data) flag_mismatch("data_out", want.data, m_tdata);
          if (m_tlast !== want.last) flag_mismatch("last_of_run", want.last, m_tlast);
        end
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("base64_stream_codec_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(input logic [7:0] data, input logic eom);
    byte_stream.push_back('{data: data, eom: eom});
    items_queued++;
  endtask

  task automatic apb_access(input logic wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_direction(input logic dir);
    logic [31:0] rd;
    apb_access(1'b1, int'(REG_DIRECTION), {31'h0, dir}, rd);
    dir_mode = dir;
    clear_group();
    // idle between the write and the readback
    @(posedge clk);
    apb_access(1'b0, int'(REG_DIRECTION), 32'h0, rd);
    if (rd !== {31'h0, dir}) flag_mismatch("direction readback", {31'h0, dir}, rd);
  endtask

  // Wait until every item is taken and every result is in, then let the block settle
  task automatic drain();
    do @(posedge clk); while (items_taken != items_queued || codec_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic gen_segment(input logic dir, input int count);
    int made;
    int len;
    int pads;
    int r;
    logic [7:0] c;
    made = 0;
    while (made < count) begin
      if (dir == DIR_ENCODE) begin
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) add_item(8'($urandom_range(255)), i == len - 1);
      end else if ($urandom_range(99) < 80) begin
        // well-formed text: whole groups of four, optionally padded at the end
        len = 4 * $urandom_range(4, 1);
        pads = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
          c = (i >= len - pads) ? PAD_CHAR : B64_CHARS[$urandom_range(63)];
          add_item(c, i == len - 1);
        end
      end else begin
        // noise: stray pads, bytes outside the alphabet, broken group lengths
        len = $urandom_range(10, 1);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(9);
          if (r <= 5) c = B64_CHARS[$urandom_range(63)];
          else if (r == 6) c = PAD_CHAR;
          else c = 8'($urandom_range(255));
          add_item(c, i == len - 1);
        end
      end
      made += len;
    end
  endtask

  initial begin
    logic [31:0] rd;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Encode from reset: two pads, one pad, full group of extremes
    add_item(8'h00, 1'b1);
    add_item(8'hFF, 1'b0);
    add_item(8'h80, 1'b1);
    add_item(8'hFB, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b1);
    add_item(8'h4D, 1'b0);
    add_item(8'h61, 1'b0);
    drain();
    // unmapped register write mid-message must leave mode and group intact
    apb_access(1'b1, REG_SPARE, 32'hFFFF_FFFF, rd);
    add_item(8'h6E, 1'b1);
    drain();

    set_direction(DIR_DECODE);
    add_item("T", 1'b0);
    add_item("W", 1'b0);
    add_item("F", 1'b0);
    add_item("u", 1'b1);
    // pad mid-group, characters after it ignored until end of message
    add_item("Q", 1'b0);
    add_item("Q", 1'b0);
    add_item(PAD_CHAR, 1'b0);
    add_item("A", 1'b0);
    add_item("B", 1'b1);
    add_item(PAD_CHAR, 1'b0);
    add_item("Z", 1'b1);
    // bytes outside the alphabet decode as zero
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item("+", 1'b0);
    add_item("/", 1'b1);
    // lone character: trailing bits dropped, nothing emitted
    add_item("9", 1'b1);
    drain();

    for (int stage = 0; stage < 3; stage++) begin
      tx_idle_pct <= (stage == 0) ? 18 : (stage == 1) ? 71 : 0;
      rx_idle_pct <= (stage == 0) ? 71 : (stage == 1) ? 18 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        set_direction(seg[0] ? DIR_DECODE : DIR_ENCODE);
        gen_segment(seg[0] ? DIR_DECODE : DIR_ENCODE, SEGMENT_ITEMS);
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("base64_stream_codec_top test passed");
    end else begin
      $display("base64_stream_codec_top test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/b64sc_pkg.sv
hdl/b64sc_front.sv
hdl/b64sc_queue.sv
hdl/b64sc_back.sv
hdl/base64_stream_codec_top.sv
tb/sv/tb_top.sv
